FILE: rtl/arc_point_at_length_defines.svh
// Assertion shorthands for the arc point block.
`ifndef ARC_POINT_AT_LENGTH_DEFINES_SVH
`define ARC_POINT_AT_LENGTH_DEFINES_SVH

// Checked while out of reset.
`define AAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define AAP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/aap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aap_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    // field widths
    localparam int LEN_W     = 31;
    localparam int RAD_W     = 31;
    localparam int SWP_W     = 20;
    localparam int DIR_W     = 32;
    localparam int PT_W      = 32;
    localparam int ANG_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int DIV_STEPS = LEN_W + 31;  // quotient bits of (len << 31) / r
    localparam int QMOD_W    = 34;          // quotient mod 2*pi in Q31
    localparam int ZW        = 34;          // CORDIC angle accumulator
    localparam int CW        = 34;          // cos/sin datapath
    localparam int VW        = 36;          // point and direction datapath
    localparam int LIM_W     = RAD_W + SWP_W;

    localparam logic [QMOD_W-1:0] TWO_PI_Q31   = 34'd13493037705;
    localparam logic [29:0]       TURN_PER_RAD = 30'd683565276;
    localparam logic [29:0]       KINV         = 30'd652032874;

    localparam logic [ANG_W-1:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [ANG_W-1:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [ANG_W-1:0] THREE_QUARTER = 32'hC000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARC_RADIUS,
        REG_SWEEP_ANGLE,
        REG_CENTER_DIR_X,
        REG_CENTER_DIR_Y
    } t_reg_idx;

    // atan(2^-i) in binary angle units (full turn = 2^32)
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function automatic logic signed [ZW-1:0] atan_at(input int k);
        return (k < 32) ? $signed({2'b00, ATAN_TAB[k[4:0]]}) : '0;
    endfunction

    // one stage of the divider / direction front end
    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    beyond;
        logic [LEN_W-1:0]        lsh;     // dividend bits still to shift in
        logic [RAD_W-1:0]        rem;
        logic [QMOD_W-1:0]       qmod;
        logic signed [VW-1:0]    vx;
        logic signed [VW-1:0]    vy;
        logic signed [ZW-1:0]    vz;
        logic [ANG_W-1:0]        base;
        logic                    fix;     // axis or null direction, angle known
        logic [ANG_W-1:0]        fixang;
    } t_front;

endpackage
`default_nettype wire

FILE: rtl/aap_front.sv
`timescale 1ns / 1ps
`default_nettype none
module aap_front #(
    parameter int K            = 0,
    parameter int CORDIC_STEPS = aap_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = aap_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic [aap_pkg::RAD_W-1:0] i_r,
    input  wire logic [aap_pkg::LIM_W-1:0] i_lim,
    input  wire aap_pkg::t_front           i_d,
    output aap_pkg::t_front                o_d
);
    import aap_pkg::*;

    localparam int LHS_W = LEN_W + FRAC_BITS;
    localparam int CMP_W = (LHS_W > LIM_W) ? LHS_W : LIM_W;

    t_front               n_d;
    t_front               r_d;
    logic [RAD_W:0]       rs;
    logic [RAD_W:0]       rdiff;
    logic                 ge;
    logic [QMOD_W:0]      q2;
    logic [QMOD_W:0]      qdiff;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] sx;
    logic signed [VW-1:0] sy;
    logic [CMP_W-1:0]     lhs;
    logic [CMP_W-1:0]     rhs;

    always_comb begin
        n_d = i_d;
        // restoring divide, one quotient bit
        rs    = {i_d.rem, i_d.lsh[LEN_W-1]};
        rdiff = rs - {1'b0, i_r};
        ge    = (rs >= {1'b0, i_r});
        n_d.rem = ge ? rdiff[RAD_W-1:0] : rs[RAD_W-1:0];
        n_d.lsh = {i_d.lsh[LEN_W-2:0], 1'b0};
        // quotient kept reduced mod 2*pi as it is built
        q2    = {i_d.qmod, ge};
        qdiff = q2 - {1'b0, TWO_PI_Q31};
        n_d.qmod = (q2 >= {1'b0, TWO_PI_Q31}) ? qdiff[QMOD_W-1:0] : q2[QMOD_W-1:0];

        // arc end test, on the whole length in the first stage
        lhs = CMP_W'({i_d.lsh, FRAC_BITS'(0)});
        rhs = CMP_W'(i_lim);
        if (K == 0) begin
            n_d.beyond = !i_d.zero && (lhs > rhs);
        end

        // vectoring CORDIC for the centre direction angle
        vx = i_d.vx;
        vy = i_d.vy;
        sx = vx >>> K;
        sy = vy >>> K;
        if (K < CORDIC_STEPS) begin
            if (vy > 0) begin
                n_d.vx = vx + sy;
                n_d.vy = vy - sx;
                n_d.vz = i_d.vz + atan_at(K);
            end else begin
                n_d.vx = vx - sy;
                n_d.vy = vy + sx;
                n_d.vz = i_d.vz - atan_at(K);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

FILE: rtl/aap_rot.sv
`timescale 1ns / 1ps
`default_nettype none
module aap_rot #(
    parameter int K   = 0,
    parameter int W   = aap_pkg::CW,
    parameter int SBW = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [W-1:0]           i_x,
    input  wire logic signed [W-1:0]           i_y,
    input  wire logic signed [aap_pkg::ZW-1:0] i_z,  // first stage: unsigned angle
    input  wire logic [SBW-1:0]                i_sb,
    output logic                               o_valid,
    output logic signed [W-1:0]                o_x,
    output logic signed [W-1:0]                o_y,
    output logic signed [aap_pkg::ZW-1:0]      o_z,
    output logic [SBW-1:0]                     o_sb
);
    import aap_pkg::*;

    logic [ANG_W-1:0]     ang;
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [ZW-1:0] az;
    logic signed [W-1:0]  sx;
    logic signed [W-1:0]  sy;
    logic signed [W-1:0]  n_x;
    logic signed [W-1:0]  n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [W-1:0]  r_x;
    logic signed [W-1:0]  r_y;
    logic signed [ZW-1:0] r_z;
    logic [SBW-1:0]       r_sb;

    always_comb begin
        ax  = i_x;
        ay  = i_y;
        az  = i_z;
        ang = i_z[ANG_W-1:0];
        // fold second and third quarter turns by a half turn
        if (K == 0) begin
            if (ang[ANG_W-1:ANG_W-2] == 2'b01 || ang[ANG_W-1:ANG_W-2] == 2'b10) begin
                ax  = -i_x;
                ay  = -i_y;
                ang = ang + HALF_TURN;
            end
            az = ZW'($signed(ang));
        end
        sx = ax >>> K;
        sy = ay >>> K;
        if (az >= 0) begin
            n_x = ax - sy;
            n_y = ay + sx;
            n_z = az - atan_at(K);
        end else begin
            n_x = ax + sy;
            n_y = ay - sx;
            n_z = az + atan_at(K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_sb    = r_sb;

endmodule
`default_nettype wire

FILE: rtl/arc_point_at_length.sv
`timescale 1ns / 1ps
`default_nettype none
// Point on a circular arc after a given length. Each request carries one
// unsigned Q16.16 length and yields one result: the point (signed Q16.16,
// saturated) and a flag set when the length runs past the configured sweep.
// One request is taken every cycle while the output skid slot is empty. The
// path is the input register, a 62-stage restoring divider that also reduces
// the angle mod 2*pi, the angle scale multiply, two CORDIC rotations of
// CORDIC_STEPS stages each with the radius multiply between them, and the
// gain multiply into the output register. The centre direction angle is found
// by a vectoring CORDIC that runs beside the divider. A two-entry output buffer
// keeps requests flowing while a result waits. The user must see that registers
// are written only when no request is in flight; the block does not enforce it.
module arc_point_at_length #(
    parameter int FRAC_BITS    = aap_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = aap_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [aap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [aap_pkg::CFG_W-1:0]     i_cfg_data,
    // requests
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // [30:0] arc_length
    // results
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [63:0]                        m_axis_tdata,  // [31:0] point_x, [63:32] point_y
    output logic [0:0]                         m_axis_tuser   // [0] beyond_arc
);
    import aap_pkg::*;

    localparam int SB1  = ANG_W + 2;
    localparam int PC_W = CW + RAD_W + 1;
    localparam int SPL  = VW / 2;
    localparam int PL_W = SPL + 30;
    localparam int PH_W = (VW - SPL) + 31;
    localparam int SUM_W = VW + 32;

    // configuration registers
    logic [RAD_W-1:0]        r_arc_radius;
    logic signed [SWP_W-1:0] r_sweep;
    logic signed [DIR_W-1:0] r_cdx;
    logic signed [DIR_W-1:0] r_cdy;
    logic [LIM_W-1:0]        r_lim;
    logic [RAD_W-1:0]        rad_eff;
    logic [SWP_W-1:0]        sweep_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arc_radius <= RAD_W'(65536);
            r_sweep      <= SWP_W'(102943);
            r_cdx        <= DIR_W'(65536);
            r_cdy        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ARC_RADIUS:   r_arc_radius <= i_cfg_data[RAD_W-1:0];
                REG_SWEEP_ANGLE:  r_sweep      <= i_cfg_data[SWP_W-1:0];
                REG_CENTER_DIR_X: r_cdx        <= i_cfg_data[DIR_W-1:0];
                REG_CENTER_DIR_Y: r_cdy        <= i_cfg_data[DIR_W-1:0];
                default:          r_cdy        <= r_cdy;
            endcase
        end
    end

    // zero radius acts as one LSB
    assign rad_eff   = (r_arc_radius == '0) ? RAD_W'(1) : r_arc_radius;
    assign sweep_mag = r_sweep[SWP_W-1] ? SWP_W'(-r_sweep) : SWP_W'(r_sweep);

    // arc length limit, refreshed from the registers every cycle
    always_ff @(posedge i_clk) begin
        r_lim <= LIM_W'(rad_eff) * LIM_W'(sweep_mag);
    end

    // whole pipe moves while the output buffer has room
    logic en;
    logic r_skid_valid;
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    // input stage, with direction setup for the vectoring CORDIC
    t_front r_s0;
    t_front n_s0;
    logic [LEN_W-1:0] len_in;
    assign len_in = s_axis_tdata[LEN_W-1:0];

    always_comb begin
        n_s0        = '0;
        n_s0.valid  = s_axis_tvalid;
        n_s0.zero   = (len_in == '0);
        n_s0.lsh    = len_in;
        n_s0.vx     = VW'(r_cdx);
        n_s0.vy     = VW'(r_cdy);
        if (r_cdx == '0 && r_cdy == '0) begin
            n_s0.fix    = 1'b1;
            n_s0.fixang = '0;
        end else if (r_cdy == '0) begin
            n_s0.fix    = 1'b1;
            n_s0.fixang = (r_cdx > 0) ? '0 : HALF_TURN;
        end else if (r_cdx == '0) begin
            n_s0.fix    = 1'b1;
            n_s0.fixang = (r_cdy > 0) ? QUARTER_TURN : THREE_QUARTER;
        end else if (r_cdx < 0) begin
            n_s0.vx   = -VW'(r_cdx);
            n_s0.vy   = -VW'(r_cdy);
            n_s0.base = HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    // divider and direction front end
    t_front w_front [DIV_STEPS+1];
    assign w_front[0] = r_s0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_front
        aap_front #(
            .K            (k),
            .CORDIC_STEPS (CORDIC_STEPS),
            .FRAC_BITS    (FRAC_BITS)
        ) u_front (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_r     (rad_eff),
            .i_lim   (r_lim),
            .i_d     (w_front[k]),
            .o_d     (w_front[k+1])
        );
    end

    // angle in turns, and the centre direction angle
    t_front                f_end;
    logic [31:0]           t_lo;
    logic [1:0]            t_hi;
    logic [61:0]           p_lo;
    logic [31:0]           p_hi;
    logic [63:0]           p_sum;
    logic [ANG_W-1:0]      n_phi;
    logic                  r_m_valid;
    logic [ANG_W-1:0]      r_m_theta;
    logic [ANG_W-1:0]      r_m_phi;
    logic                  r_m_zero;
    logic                  r_m_beyond;

    assign f_end = w_front[DIV_STEPS];
    assign t_lo  = f_end.qmod[31:0];
    assign t_hi  = f_end.qmod[QMOD_W-1:32];
    assign p_lo  = 62'(t_lo) * 62'(TURN_PER_RAD);
    assign p_hi  = 32'(t_hi) * 32'(TURN_PER_RAD);
    assign p_sum = {2'b00, p_lo} + {p_hi, 32'b0};
    assign n_phi = f_end.fix ? f_end.fixang : (f_end.base + f_end.vz[ANG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= f_end.valid;
        end
        if (en) begin
            r_m_theta  <= p_sum[62:31];
            r_m_phi    <= n_phi;
            r_m_zero   <= f_end.zero;
            r_m_beyond <= f_end.beyond;
        end
    end

    // first rotation: cos and sin of the travelled angle, Q30
    logic                 w1_v  [CORDIC_STEPS+1];
    logic signed [CW-1:0] w1_x  [CORDIC_STEPS+1];
    logic signed [CW-1:0] w1_y  [CORDIC_STEPS+1];
    logic signed [ZW-1:0] w1_z  [CORDIC_STEPS+1];
    logic [SB1-1:0]       w1_sb [CORDIC_STEPS+1];

    assign w1_v[0]  = r_m_valid;
    assign w1_x[0]  = CW'($signed({1'b0, KINV}));
    assign w1_y[0]  = '0;
    assign w1_z[0]  = ZW'({2'b00, r_m_theta});
    assign w1_sb[0] = {r_m_phi, r_m_zero, r_m_beyond};

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot1
        aap_rot #(.K(k), .W(CW), .SBW(SB1)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w1_v[k]),
            .i_x     (w1_x[k]),
            .i_y     (w1_y[k]),
            .i_z     (w1_z[k]),
            .i_sb    (w1_sb[k]),
            .o_valid (w1_v[k+1]),
            .o_x     (w1_x[k+1]),
            .o_y     (w1_y[k+1]),
            .o_z     (w1_z[k+1]),
            .o_sb    (w1_sb[k+1])
        );
    end

    // radius times cos and sin
    logic signed [PC_W-1:0] r_p_pc;
    logic signed [PC_W-1:0] r_p_ps;
    logic                   r_p_valid;
    logic [SB1-1:0]         r_p_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= w1_v[CORDIC_STEPS];
        end
        if (en) begin
            r_p_pc <= $signed({1'b0, rad_eff}) * w1_x[CORDIC_STEPS];
            r_p_ps <= $signed({1'b0, rad_eff}) * w1_y[CORDIC_STEPS];
            r_p_sb <= w1_sb[CORDIC_STEPS];
        end
    end

    // local point, y mirrored for a clockwise sweep
    logic signed [PC_W-1:0] pc_rnd;
    logic signed [PC_W-1:0] ps_rnd;
    logic signed [VW-1:0]   rc;
    logic signed [VW-1:0]   rsn;
    logic signed [VW-1:0]   r_q_px;
    logic signed [VW-1:0]   r_q_py;
    logic                   r_q_valid;
    logic [SB1-1:0]         r_q_sb;

    assign pc_rnd = r_p_pc + PC_W'(1 << 29);
    assign ps_rnd = r_p_ps + PC_W'(1 << 29);
    assign rc     = VW'(pc_rnd >>> 30);
    assign rsn    = VW'(ps_rnd >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (en) begin
            r_q_valid <= r_p_valid;
        end
        if (en) begin
            r_q_px <= $signed(VW'(rad_eff)) - rc;
            r_q_py <= r_sweep[SWP_W-1] ? -rsn : rsn;
            r_q_sb <= r_p_sb;
        end
    end

    // second rotation: by the centre direction angle
    logic                 w2_v  [CORDIC_STEPS+1];
    logic signed [VW-1:0] w2_x  [CORDIC_STEPS+1];
    logic signed [VW-1:0] w2_y  [CORDIC_STEPS+1];
    logic signed [ZW-1:0] w2_z  [CORDIC_STEPS+1];
    logic [1:0]           w2_sb [CORDIC_STEPS+1];

    assign w2_v[0]  = r_q_valid;
    assign w2_x[0]  = r_q_px;
    assign w2_y[0]  = r_q_py;
    assign w2_z[0]  = ZW'({2'b00, r_q_sb[SB1-1:2]});
    assign w2_sb[0] = r_q_sb[1:0];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot2
        aap_rot #(.K(k), .W(VW), .SBW(2)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w2_v[k]),
            .i_x     (w2_x[k]),
            .i_y     (w2_y[k]),
            .i_z     (w2_z[k]),
            .i_sb    (w2_sb[k]),
            .o_valid (w2_v[k+1]),
            .o_x     (w2_x[k+1]),
            .o_y     (w2_y[k+1]),
            .o_z     (w2_z[k+1]),
            .o_sb    (w2_sb[k+1])
        );
    end

    // gain correction, split in two partial products per coordinate
    logic signed [VW-1:0]   vx2;
    logic signed [VW-1:0]   vy2;
    logic [PL_W-1:0]        r_f_xl;
    logic [PL_W-1:0]        r_f_yl;
    logic signed [PH_W-1:0] r_f_xh;
    logic signed [PH_W-1:0] r_f_yh;
    logic                   r_f_valid;
    logic [1:0]             r_f_sb;

    assign vx2 = w2_x[CORDIC_STEPS];
    assign vy2 = w2_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= w2_v[CORDIC_STEPS];
        end
        if (en) begin
            r_f_xl <= PL_W'(vx2[SPL-1:0]) * PL_W'(KINV);
            r_f_yl <= PL_W'(vy2[SPL-1:0]) * PL_W'(KINV);
            r_f_xh <= $signed(vx2[VW-1:SPL]) * $signed({1'b0, KINV});
            r_f_yh <= $signed(vy2[VW-1:SPL]) * $signed({1'b0, KINV});
            r_f_sb <= w2_sb[CORDIC_STEPS];
        end
    end

    function automatic logic [PT_W-1:0] round_sat(
        input logic signed [PH_W-1:0] hi,
        input logic [PL_W-1:0]        lo
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        s = (SUM_W'(hi) <<< SPL) + $signed(SUM_W'(lo)) + SUM_W'(1 << 29);
        q = s >>> 30;
        if (q > $signed(SUM_W'(32'h7FFF_FFFF))) begin
            return 32'h7FFF_FFFF;
        end else if (q < -$signed(SUM_W'(33'h1_0000_0000)) >>> 1) begin
            return 32'h8000_0000;
        end
        return q[PT_W-1:0];
    endfunction

    logic [PT_W-1:0] res_x;
    logic [PT_W-1:0] res_y;
    logic            res_b;

    assign res_x = r_f_sb[1] ? '0 : round_sat(r_f_xh, r_f_xl);
    assign res_y = r_f_sb[1] ? '0 : round_sat(r_f_yh, r_f_yl);
    assign res_b = r_f_sb[0];

    // output register with a one-entry skid
    logic            r_out_valid;
    logic [PT_W-1:0] r_out_x;
    logic [PT_W-1:0] r_out_y;
    logic            r_out_b;
    logic [PT_W-1:0] r_skid_x;
    logic [PT_W-1:0] r_skid_y;
    logic            r_skid_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_x      <= r_skid_x;
                r_out_y      <= r_skid_y;
                r_out_b      <= r_skid_b;
                r_skid_valid <= 1'b0;
            end
        end else if (r_f_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_x     <= res_x;
                r_out_y     <= res_y;
                r_out_b     <= res_b;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_x     <= res_x;
                r_skid_y     <= res_y;
                r_skid_b     <= res_b;
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_b;

endmodule
`default_nettype wire

FILE: rtl/aap_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "arc_point_at_length_defines.svh"
module aap_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // a stalled result holds
    `AAP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // requests stop only when both output slots hold results
    `AAP_ASSERT(a_stall_full, !s_axis_tready |-> m_axis_tvalid, "input stalled with output empty")

    // a taken result frees the skid slot at once
    `AAP_ASSERT(a_skid_drain, !s_axis_tready && m_axis_tready |=> s_axis_tready, "skid slot not drained")

    // reset empties the output side
    `AAP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "output not empty after reset")

endmodule

bind arc_point_at_length aap_chk u_aap_chk (.*);
`default_nettype wire
